@@ rtl/core/timed_neighbor_table_core_defines.svh @@
// Assertion macros used by the neighbor table back part.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef TIMED_NEIGHBOR_TABLE_CORE_DEFINES_SVH
`define TIMED_NEIGHBOR_TABLE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TNT_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TNT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TNT_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TNT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/core/tnt_pkg.sv @@
// Shared types and constants of the timed neighbor table.
// No dependencies.
package tnt_pkg;
    localparam int DEFAULT_ENTRIES = 16;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0]
    {
        ACT_UPDATE = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_TXERR  = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_LOST  = 1'b1;

    typedef struct packed
    {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] lifetime;
        logic [47:0] hw_address;
    } req_t;

    typedef struct packed
    {
        logic        kind;
        logic [31:0] lost_address;
        logic        found;
        logic [31:0] remaining;
        logic        table_full;
        logic        last;
    } rsp_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed
    {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] expiry;
        logic [47:0] hw_address;
    } cmd_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TIME_MAX : s[31:0];
    endfunction
endpackage

@@ rtl/core/tnt_if.sv @@
// Valid/ready channel carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
interface tnt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/tnt_front.sv @@
// Front part: accepts requests, folds time in and queues commands.
// Depends on tnt_pkg.
module tnt_front
    import tnt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tnt_if.sink         in_ch,
    input  logic [31:0] now,
    input  logic        cmd_take,
    output logic        cmd_valid,
    output cmd_t        cmd
);
    // Command queue with two slots; it takes a request only when empty, so holds one.
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       push, pop;
    cmd_t       c;
    logic [31:0] add;

    always_comb
    begin
        add = (in_ch.data.action == ACT_TICK) ? 32'd1 : in_ch.data.lifetime;
        c.action     = in_ch.data.action;
        c.address    = in_ch.data.address;
        c.hw_address = in_ch.data.hw_address;
        c.expiry     = sat_add(now, add);
    end

    assign in_ch.ready = (cnt_reg == 2'd0);
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = cmd_take && cmd_valid;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                q_reg[rd_reg ^ cnt_reg[0]] <= c;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/core/tnt_back.sv @@
// Back part: table storage, lookup, insert and the serial purge sweep.
// Depends on tnt_pkg and the assertion macro header.
`include "timed_neighbor_table_core_defines.svh"
module tnt_back
    import tnt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic [31:0] now,
    tnt_if.source       out_ch
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] { S_IDLE, S_SWEEP, S_FINISH } state_t;

    state_t           state_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]      ip_reg  [ENTRIES];
    logic [47:0]      mac_reg [ENTRIES];
    logic [31:0]      exp_reg [ENTRIES];
    logic [31:0]      time_reg;
    cmd_t             cur_reg;
    logic [IW-1:0]    idx_reg;
    logic             ov_reg;
    rsp_t             out_reg;

    // Match search over all entries.
    logic [ENTRIES-1:0] hit;
    logic             any_hit, any_free;
    logic [IW-1:0]    hit_idx, free_idx;
    always_comb
    begin
        any_hit = 1'b0; any_free = 1'b0;
        hit_idx = '0; free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            hit[i] = valid_reg[i] && ip_reg[i] == cur_reg.address;
            if (hit[i])
            begin
                any_hit = 1'b1; hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1; free_idx = IW'(i);
            end
        end
    end

    // Drop condition of the entry under the sweep.
    logic drop;
    assign drop = valid_reg[idx_reg] &&
        (exp_reg[idx_reg] < time_reg ||
         (cur_reg.action == ACT_TXERR && mac_reg[idx_reg] == cur_reg.hw_address));

    logic out_free;
    assign out_free = !ov_reg || out_ch.ready;
    assign now = time_reg;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && out_free;
    assign out_ch.valid = ov_reg;
    assign out_ch.data = out_reg;

    logic last_idx;
    assign last_idx = (idx_reg == IW'(ENTRIES - 1));

    // An update hit is refreshed in place on the first sweep cycle.
    logic upd_hit;
    assign upd_hit = (cur_reg.action == ACT_UPDATE) && any_hit && (idx_reg == '0);

    // A beat is loaded into the output register on a drop or on the final reply.
    logic emit;
    assign emit = out_free &&
        ((state_reg == S_SWEEP && !upd_hit && drop) || state_reg == S_FINISH);

    // Final reply of the current command.
    rsp_t reply;
    always_comb
    begin
        reply = '{kind: KIND_REPLY, lost_address: '0, found: 1'b0,
                  remaining: '0, table_full: 1'b0, last: 1'b1};
        case (cur_reg.action)
            ACT_UPDATE:
            begin
                if (any_hit)
                    reply.found = 1'b1;
                else if (!any_free)
                    reply.table_full = 1'b1;
            end
            ACT_QUERY:
            begin
                if (any_hit)
                begin
                    reply.found = 1'b1;
                    reply.remaining = exp_reg[hit_idx] - time_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            time_reg  <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        cur_reg <= cmd;
                        idx_reg <= '0;
                        if (cmd.action == ACT_TICK)
                            time_reg <= cmd.expiry;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    // Update hit: refresh in place, no purge.
                    if (upd_hit)
                    begin
                        if (cur_reg.expiry > exp_reg[hit_idx])
                            exp_reg[hit_idx] <= cur_reg.expiry;
                        if (mac_reg[hit_idx] == '0)
                            mac_reg[hit_idx] <= cur_reg.hw_address;
                        state_reg <= S_FINISH;
                    end
                    else if (out_free)
                    begin
                        if (drop)
                        begin
                            valid_reg[idx_reg] <= 1'b0;
                            out_reg <= '{kind: KIND_LOST, lost_address: ip_reg[idx_reg],
                                         found: 1'b0, remaining: '0, table_full: 1'b0,
                                         last: 1'b0};
                        end
                        if (last_idx)
                            state_reg <= S_FINISH;
                        else
                            idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_reg <= reply;
                        // Update miss goes into the lowest free entry.
                        if (cur_reg.action == ACT_UPDATE && !any_hit && any_free)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            ip_reg[free_idx]  <= cur_reg.address;
                            mac_reg[free_idx] <= cur_reg.hw_address;
                            exp_reg[free_idx] <= cur_reg.expiry;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `TNT_ASSERT_IMPL(a_take_idle, clk, rst_n, cmd_take, state_reg == S_IDLE)
    `TNT_ASSERT_NEXT(a_tick_time, clk, rst_n, cmd_take && cmd.action == ACT_TICK,
        time_reg == $past(cmd.expiry))
    `TNT_ASSERT_IMPL(a_lost_not_last, clk, rst_n, ov_reg, out_reg.last != out_reg.kind)
endmodule

@@ rtl/core/timed_neighbor_table_core.sv @@
// Timed neighbor table: the front registers each input beat as a command; the back
// part takes it when idle, sweeps the entries (an update hit is refreshed instead)
// and then registers the final reply, and takes one command at a time.
// The serial purge sweep over the entries, one per cycle, sets the rate;
// a stalled output holds the sweep. The front takes the next item meanwhile.
// Reset clears all valid bits and the time at once; no clearing pass.
module timed_neighbor_table_core
    import tnt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic  clk,
    input  logic  rst_n,
    tnt_if.sink   in_ch,
    tnt_if.source out_ch
);
    logic        cmd_valid, cmd_take;
    cmd_t        cmd;
    logic [31:0] now;

    tnt_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .now(now),
        .cmd_take(cmd_take), .cmd_valid(cmd_valid), .cmd(cmd)
    );

    tnt_back #(.ENTRIES(ENTRIES)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .now(now), .out_ch(out_ch)
    );
endmodule

@@ sim/tnt_checker.sv @@
// Scoreboard for the timed neighbor table: watches both channels, keeps a
// shadow copy of the table and compares every result beat in order.
// Depends on tnt_pkg and the tnt_if interface.
module tnt_checker
    import tnt_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic clk,
    input  logic rst_n,
    tnt_if       in_ch,
    tnt_if       out_ch,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the table.
    logic        slot_used [ENTRIES];
    logic [31:0] slot_ip   [ENTRIES];
    logic [47:0] slot_mac  [ENTRIES];
    logic [31:0] slot_exp  [ENTRIES];
    logic [31:0] now_ticks;

    rsp_t expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic rsp_t make_rsp(input logic kind, input logic [31:0] lost,
                                      input logic found, input logic [31:0] rem,
                                      input logic full, input logic fin);
        rsp_t r;
        r.kind = kind;
        r.lost_address = lost;
        r.found = found;
        r.remaining = rem;
        r.table_full = full;
        r.last = fin;
        return r;
    endfunction

    // Appends one expected beat at the tail of the queue.
    task automatic expect_beat(input rsp_t r);
        expected_rsp_q.insert(expected_rsp_q.size(), r);
    endtask

    // Drops stale slots, and slots with a matching MAC when asked, in slot order.
    task automatic drop_neighbors(input bit by_mac, input logic [47:0] mac);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_used[i] && (slot_exp[i] < now_ticks || (by_mac && slot_mac[i] == mac)))
            begin
                slot_used[i] = 1'b0;
                expect_beat(make_rsp(KIND_LOST, slot_ip[i], 1'b0, 32'd0, 1'b0, 1'b0));
            end
        end
    endtask

    function automatic int lookup_slot(input logic [31:0] addr);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_ip[i] == addr)
                return i;
        return -1;
    endfunction

    // Applies one request beat to the shadow table and queues its results.
    task automatic predict_neighbor_event(input req_t req);
        int          hit;
        int          free_slot;
        logic [31:0] new_exp;
        logic        found;
        logic [31:0] rem;
        logic        full;
        found = 1'b0;
        rem = 32'd0;
        full = 1'b0;
        case (action_t'(req.action))
            ACT_UPDATE:
            begin
                new_exp = clamp_add(now_ticks, req.lifetime);
                hit = lookup_slot(req.address);
                if (hit >= 0)
                begin
                    found = 1'b1;
                    if (new_exp > slot_exp[hit])
                        slot_exp[hit] = new_exp;
                    if (slot_mac[hit] == 48'd0)
                        slot_mac[hit] = req.hw_address;
                end
                else
                begin
                    drop_neighbors(1'b0, 48'd0);
                    free_slot = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!slot_used[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        slot_used[free_slot] = 1'b1;
                        slot_ip[free_slot] = req.address;
                        slot_mac[free_slot] = req.hw_address;
                        slot_exp[free_slot] = new_exp;
                    end
                    else
                        full = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                drop_neighbors(1'b0, 48'd0);
                hit = lookup_slot(req.address);
                if (hit >= 0)
                begin
                    found = 1'b1;
                    rem = slot_exp[hit] - now_ticks;
                end
            end
            ACT_TXERR:
                drop_neighbors(1'b1, req.hw_address);
            default:
            begin
                now_ticks = clamp_add(now_ticks, 32'd1);
                drop_neighbors(1'b0, 48'd0);
            end
        endcase
        expect_beat(make_rsp(KIND_REPLY, 32'd0, found, rem, full, 1'b1));
    endtask

    // Reports one field mismatch.
    task automatic flag_field(input string name, input logic [47:0] exp_v,
                              input logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Sample accepted beats on both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_used[i] = 1'b0;
            now_ticks = 32'd0;
            expected_rsp_q.delete();
            errors = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %0h",
                             $time, out_ch.data);
                    errors++;
                end
                else
                begin
                    rsp_t want;
                    rsp_t got;
                    want = expected_rsp_q.pop_front();
                    got = out_ch.data;
                    flag_field("kind", want.kind, got.kind);
                    flag_field("lost_address", want.lost_address, got.lost_address);
                    flag_field("found", want.found, got.found);
                    flag_field("remaining", want.remaining, got.remaining);
                    flag_field("table_full", want.table_full, got.table_full);
                    flag_field("last", want.last, got.last);
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_neighbor_event(in_ch.data);
        end
    end
endmodule

@@ sim/tb_top.sv @@
// Top of the neighbor table testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on tnt_pkg, tnt_if,
// tnt_checker and timed_neighbor_table_core.
module tb_top;
    import tnt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   hold_off_req;

    tnt_if #(.T(req_t)) in_ch();
    tnt_if #(.T(rsp_t)) out_ch();

    timed_neighbor_table_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    tnt_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                     .errors(errors), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly back-to-back, sometimes short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request beat and waits for it to be taken.
    task automatic send_beat(input action_t act, input logic [31:0] addr,
                             input logic [31:0] life, input logic [47:0] mac);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= '{action: act, address: addr, lifetime: life, hw_address: mac};
        do
            @(posedge clk);
        while (!in_ch.ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 0;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Cycle limit guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed_neighbor_table_core test failed");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [31:0] ip_pool [24];
        logic [47:0] mac_pool [6];
        action_t     act;
        logic [31:0] addr;
        logic [31:0] life;
        logic [47:0] mac;
        int          r;
        cycles = 0;
        hold_off_req = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, refresh with MAC fill, misses, drops.
        send_beat(ACT_UPDATE, 32'h0, 32'h0, 48'h0);
        send_beat(ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_beat(ACT_QUERY, 32'h0, 32'h0, 48'h0);
        send_beat(ACT_QUERY, 32'hFFFF_FFFF, 32'h0, 48'h0);
        send_beat(ACT_UPDATE, 32'h0, 32'd5, 48'h1234_5678_9ABC);
        send_beat(ACT_UPDATE, 32'h0, 32'd1, 48'hFFFF_FFFF_FFFF);
        send_beat(ACT_QUERY, 32'h1234_5678, 32'h0, 48'h0);
        send_beat(ACT_TXERR, 32'h0, 32'h0, 48'h0);
        send_beat(ACT_UPDATE, 32'h55, 32'h0, 48'h0);
        send_beat(ACT_TXERR, 32'h0, 32'h0, 48'h0);
        send_beat(ACT_UPDATE, 32'h66, 32'h0, 48'h1);
        send_beat(ACT_TICK, 32'h0, 32'h0, 48'h0);
        send_beat(ACT_TICK, 32'h0, 32'h0, 48'h0);
        // Fill the table past its capacity so an insert is refused.
        for (int i = 0; i < 17; i++)
            send_beat(ACT_UPDATE, 32'h1000 + i, 32'd100, 48'hA0 + i);
        send_beat(ACT_TXERR, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_beat(ACT_QUERY, 32'h1003, 32'h0, 48'h0);

        // Random: a small address pool so refreshes, hits and drops are common.
        for (int i = 0; i < 24; i++)
            ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        for (int i = 2; i < 6; i++)
            mac_pool[i] = 48'({$urandom, $urandom});
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 60)
                hold_off_req = 1;
            r = $urandom_range(0, 99);
            act = (r < 40) ? ACT_UPDATE : (r < 65) ? ACT_QUERY : (r < 75) ? ACT_TXERR : ACT_TICK;
            addr = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 23)];
            r = $urandom_range(0, 9);
            life = (r < 8) ? $urandom_range(0, 30) : (r == 8) ? $urandom : 32'hFFFF_FFFF;
            mac = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom})
                                              : mac_pool[$urandom_range(0, 5)];
            send_beat(act, addr, life, mac);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("timed_neighbor_table_core test passed");
        else
            $display("timed_neighbor_table_core test failed");
        $finish;
    end
endmodule

@@ timed_neighbor_table_core.f @@
+incdir+rtl/core
rtl/core/tnt_pkg.sv
rtl/core/tnt_if.sv
rtl/core/tnt_front.sv
rtl/core/tnt_back.sv
rtl/core/timed_neighbor_table_core.sv
sim/tnt_checker.sv
sim/tb_top.sv
